>>> rtl/core/m44i_pkg.sv
// ----------------------------------------------------------------------------
// m44i_pkg
// Types and constants shared by the 4x4 matrix inverse modules.
// ----------------------------------------------------------------------------
`default_nettype none

package m44i_pkg;

  localparam int DATA_W      = 32;
  localparam int IDX_W       = 4;
  localparam int ELEMS       = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int MINORS      = 18;
  localparam int MINOR_AW    = 5;
  localparam int MIN_W       = 65;
  localparam int COF_W       = 97;
  localparam int ACC_W       = 131;
  localparam int OPB_W       = 33;
  localparam int PROD_W      = 66;
  localparam int DIV_W       = 165;
  localparam int WAIT_CYCLES = 3;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  index;
  } elem_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MINOR,
    ST_COF,
    ST_DET,
    ST_WAIT,
    ST_DSETUP,
    ST_DREAD,
    ST_DGO,
    ST_DRUN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_PREP,
    DV_RUN,
    DV_DONE
  } div_state_t;

  typedef enum logic [1:0] {
    SRC_ELEM,
    SRC_MINOR,
    SRC_COF
  } src_t;

  typedef enum logic [1:0] {
    DST_MINOR,
    DST_COF,
    DST_DET
  } dst_t;

  typedef struct packed {
    logic                valid;
    src_t                src;
    dst_t                dst;
    logic [1:0]          limb;
    logic                neg;
    logic                first;
    logic                last;
    logic [MINOR_AW-1:0] dest;
  } mac_op_t;

  typedef struct packed {
    logic             start;
    logic [COF_W-1:0] cof;
    logic [ACC_W-1:0] det_mag;
    logic             det_neg;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [1:0] col_lo(input logic [2:0] cp);
    case (cp)
      3'd0, 3'd1, 3'd2: col_lo = 2'd0;
      3'd3, 3'd4:       col_lo = 2'd1;
      default:          col_lo = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] col_hi(input logic [2:0] cp);
    case (cp)
      3'd0:       col_hi = 2'd1;
      3'd1, 3'd3: col_hi = 2'd2;
      default:    col_hi = 2'd3;
    endcase
  endfunction

  function automatic logic [2:0] pair_index(input logic [1:0] a, input logic [1:0] b);
    if (a == 2'd0) begin
      pair_index = {1'b0, b} - 3'd1;
    end else if (a == 2'd1) begin
      pair_index = {1'b0, b} + 3'd1;
    end else begin
      pair_index = 3'd5;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/m44i_front.sv
// ----------------------------------------------------------------------------
// m44i_front
// Accepts matrix elements and tags each with its row-major position.
// ----------------------------------------------------------------------------
`default_nettype none

module m44i_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [m44i_pkg::DATA_W-1:0] element_value,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  output m44i_pkg::elem_t                 push_data,
  output logic                            push_valid,
  input  wire logic                       push_ready
);

  logic [m44i_pkg::IDX_W-1:0] load_count;

  assign in_ready         = push_ready;
  assign push_valid       = in_valid;
  assign push_data.value  = element_value;
  assign push_data.index  = load_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (in_valid && push_ready) begin
      load_count <= load_count + m44i_pkg::IDX_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/m44i_queue.sv
// ----------------------------------------------------------------------------
// m44i_queue
// Short first-in first-out queue between the front and the compute engine.
// ----------------------------------------------------------------------------
`default_nettype none

module m44i_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire m44i_pkg::elem_t push_data,
  input  wire logic            push_valid,
  output logic                 push_ready,
  output m44i_pkg::elem_t      pop_data,
  output logic                 pop_valid,
  input  wire logic            pop
);

  m44i_pkg::elem_t                store [m44i_pkg::QUEUE_DEPTH];
  logic [m44i_pkg::QPTR_W-1:0]    wr_ptr;
  logic [m44i_pkg::QPTR_W-1:0]    rd_ptr;
  logic [m44i_pkg::QPTR_W:0]      count;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (count != (m44i_pkg::QPTR_W + 1)'(m44i_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = store[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + m44i_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + m44i_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (m44i_pkg::QPTR_W + 1)'(1);
      end else if (!do_push && do_pop) begin
        count <= count - (m44i_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/m44i_divider.sv
// ----------------------------------------------------------------------------
// m44i_divider
// Bit-serial restoring divider forming round(C * 2^(2F) / D), saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module m44i_divider #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire m44i_pkg::div_req_t req,
  output m44i_pkg::div_rsp_t      rsp
);

  localparam int SHIFT = 2 * FRAC_BITS + 1;

  m44i_pkg::div_state_t          state;
  m44i_pkg::div_state_t          state_next;
  logic [m44i_pkg::DIV_W-1:0]    rem;
  logic [m44i_pkg::DIV_W-1:0]    dsh;
  logic [m44i_pkg::DATA_W-1:0]   quot;
  logic [4:0]                    cnt;
  logic                          neg;
  logic                          sat;
  logic                          cof_neg;
  logic [m44i_pkg::COF_W-1:0]    cof_mag;
  logic                          ge;
  logic [m44i_pkg::DATA_W-1:0]   limit;
  logic [m44i_pkg::DATA_W-1:0]   clamped;

  assign cof_neg = req.cof[m44i_pkg::COF_W-1];
  assign cof_mag = cof_neg ? (~req.cof + m44i_pkg::COF_W'(1)) : req.cof;
  assign ge      = (rem >= dsh);
  assign limit   = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign clamped = (sat || (quot > limit)) ? limit : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m44i_pkg::DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rsp.done   = 1'b0;
    rsp.quot   = neg ? (~clamped + m44i_pkg::DATA_W'(1)) : clamped;
    case (state)
      m44i_pkg::DV_IDLE: begin
        if (req.start) begin
          state_next = m44i_pkg::DV_PREP;
        end
      end
      m44i_pkg::DV_PREP: begin
        state_next = m44i_pkg::DV_RUN;
      end
      m44i_pkg::DV_RUN: begin
        if (cnt == 5'd31) begin
          state_next = m44i_pkg::DV_DONE;
        end
      end
      m44i_pkg::DV_DONE: begin
        rsp.done   = 1'b1;
        state_next = m44i_pkg::DV_IDLE;
      end
      default: begin
        state_next = m44i_pkg::DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      m44i_pkg::DV_IDLE: begin
        rem <= (m44i_pkg::DIV_W'(cof_mag) << SHIFT) + m44i_pkg::DIV_W'(req.det_mag);
        dsh <= m44i_pkg::DIV_W'(req.det_mag) << 33;
        neg <= cof_neg ^ req.det_neg;
      end
      m44i_pkg::DV_PREP: begin
        sat  <= ge;
        dsh  <= dsh >> 1;
        cnt  <= '0;
        quot <= '0;
      end
      m44i_pkg::DV_RUN: begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quot <= {quot[m44i_pkg::DATA_W-2:0], ge};
        dsh  <= dsh >> 1;
        cnt  <= cnt + 5'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/m44i_engine.sv
// ----------------------------------------------------------------------------
// m44i_engine
// Loads a matrix, forms minors, adjugate and determinant on one shared
// multiply-accumulate unit, then drives the divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module m44i_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire m44i_pkg::elem_t             q_data,
  input  wire logic                        q_valid,
  output logic                             q_pop,
  output m44i_pkg::div_req_t               div_req,
  input  wire m44i_pkg::div_rsp_t          div_rsp,
  output logic [m44i_pkg::DATA_W-1:0]      result_value,
  output logic [m44i_pkg::IDX_W-1:0]       result_index,
  output logic                             singular,
  output logic                             last_result,
  output logic                             out_valid,
  input  wire logic                        out_ready
);

  m44i_pkg::state_t              state;
  m44i_pkg::state_t              state_next;
  m44i_pkg::state_t              wait_ret;
  m44i_pkg::state_t              wait_ret_next;
  logic [1:0]                    wcnt;
  logic [1:0]                    wcnt_next;
  logic [m44i_pkg::MINOR_AW-1:0] mi;
  logic [m44i_pkg::MINOR_AW-1:0] mi_next;
  logic [1:0]                    rp;
  logic [1:0]                    rp_next;
  logic [2:0]                    cp;
  logic [2:0]                    cp_next;
  logic [1:0]                    term;
  logic [1:0]                    term_next;
  logic [1:0]                    limb;
  logic [1:0]                    limb_next;
  logic [m44i_pkg::IDX_W-1:0]    k;
  logic [m44i_pkg::IDX_W-1:0]    k_next;

  logic [m44i_pkg::DATA_W-1:0]   mem [m44i_pkg::ELEMS];
  logic [m44i_pkg::IDX_W-1:0]    rd_addr_a;
  logic [m44i_pkg::IDX_W-1:0]    rd_addr_b;
  logic [m44i_pkg::DATA_W-1:0]   rd_a;
  logic [m44i_pkg::DATA_W-1:0]   rd_b;

  logic [m44i_pkg::MIN_W-1:0]    minor_bank [m44i_pkg::MINORS];
  logic [m44i_pkg::MINOR_AW-1:0] minor_addr;
  logic [m44i_pkg::MIN_W-1:0]    minor_rd;
  logic [m44i_pkg::COF_W-1:0]    cof_bank [m44i_pkg::ELEMS];
  logic [m44i_pkg::IDX_W-1:0]    cof_addr;
  logic [m44i_pkg::COF_W-1:0]    cof_rd;

  m44i_pkg::mac_op_t             op;
  m44i_pkg::mac_op_t             s1_op;
  m44i_pkg::mac_op_t             s2_op;
  logic signed [m44i_pkg::OPB_W-1:0]  a_opd;
  logic signed [m44i_pkg::OPB_W-1:0]  b_opd;
  logic signed [m44i_pkg::PROD_W-1:0] prod;
  logic signed [m44i_pkg::ACC_W-1:0]  term_ext;
  logic signed [m44i_pkg::ACC_W-1:0]  term_sh;
  logic signed [m44i_pkg::ACC_W-1:0]  acc_base;
  logic signed [m44i_pkg::ACC_W-1:0]  acc_next;
  logic signed [m44i_pkg::ACC_W-1:0]  acc;
  logic [m44i_pkg::ACC_W-1:0]    det;
  logic [m44i_pkg::ACC_W-1:0]    det_mag;
  logic                          det_neg;
  logic                          det_zero;
  logic [m44i_pkg::DATA_W-1:0]   q_res;
  logic                          res_load;

  logic [1:0] row;
  logic [1:0] col;
  logic [1:0] rs0;
  logic [1:0] cs0;
  logic [1:0] cs1;
  logic [1:0] cs2;
  logic [1:0] pa;
  logic [1:0] pb;
  logic [1:0] asel;
  logic [1:0] rpk;
  logic [1:0] mr1;
  logic [1:0] mr2;
  logic [1:0] mca;
  logic [1:0] mcb;

  assign row  = k[1:0];
  assign col  = k[3:2];
  assign rs0  = (row == 2'd0) ? 2'd1 : 2'd0;
  assign cs0  = (col == 2'd0) ? 2'd1 : 2'd0;
  assign cs1  = (col <= 2'd1) ? 2'd2 : 2'd1;
  assign cs2  = (col == 2'd3) ? 2'd2 : 2'd3;
  assign pa   = (term == 2'd0) ? cs1 : cs0;
  assign pb   = (term == 2'd2) ? cs1 : cs2;
  assign asel = (term == 2'd0) ? cs0 : ((term == 2'd1) ? cs1 : cs2);
  assign rpk  = (row <= 2'd1) ? 2'd0 : ((row == 2'd2) ? 2'd1 : 2'd2);
  assign mr1  = (rp == 2'd0) ? 2'd2 : 2'd1;
  assign mr2  = (rp == 2'd2) ? 2'd2 : 2'd3;
  assign mca  = m44i_pkg::col_lo(cp);
  assign mcb  = m44i_pkg::col_hi(cp);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= m44i_pkg::ST_LOAD;
      wait_ret <= m44i_pkg::ST_LOAD;
      wcnt     <= '0;
      mi       <= '0;
      rp       <= '0;
      cp       <= '0;
      term     <= '0;
      limb     <= '0;
      k        <= '0;
    end else begin
      state    <= state_next;
      wait_ret <= wait_ret_next;
      wcnt     <= wcnt_next;
      mi       <= mi_next;
      rp       <= rp_next;
      cp       <= cp_next;
      term     <= term_next;
      limb     <= limb_next;
      k        <= k_next;
    end
  end

  always_comb begin
    state_next      = state;
    wait_ret_next   = wait_ret;
    wcnt_next       = wcnt;
    mi_next         = mi;
    rp_next         = rp;
    cp_next         = cp;
    term_next       = term;
    limb_next       = limb;
    k_next          = k;
    op              = '0;
    rd_addr_a       = '0;
    rd_addr_b       = '0;
    minor_addr      = '0;
    cof_addr        = k;
    q_pop           = 1'b0;
    res_load        = 1'b0;
    div_req.start   = 1'b0;
    div_req.cof     = cof_rd;
    div_req.det_mag = det_mag;
    div_req.det_neg = det_neg;
    case (state)
      m44i_pkg::ST_LOAD: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_data.index == m44i_pkg::IDX_W'(m44i_pkg::ELEMS - 1)) begin
            state_next = m44i_pkg::ST_MINOR;
            mi_next    = '0;
            rp_next    = '0;
            cp_next    = '0;
            term_next  = '0;
          end
        end
      end
      m44i_pkg::ST_MINOR: begin
        rd_addr_a = (term == 2'd0) ? {mr1, mca} : {mr1, mcb};
        rd_addr_b = (term == 2'd0) ? {mr2, mcb} : {mr2, mca};
        op.valid  = 1'b1;
        op.src    = m44i_pkg::SRC_ELEM;
        op.dst    = m44i_pkg::DST_MINOR;
        op.limb   = 2'd0;
        op.neg    = term[0];
        op.first  = (term == 2'd0);
        op.last   = (term == 2'd1);
        op.dest   = mi;
        if (term == 2'd0) begin
          term_next = 2'd1;
        end else begin
          term_next = 2'd0;
          mi_next   = mi + m44i_pkg::MINOR_AW'(1);
          if (cp == 3'd5) begin
            cp_next = 3'd0;
            rp_next = rp + 2'd1;
          end else begin
            cp_next = cp + 3'd1;
          end
          if (mi == m44i_pkg::MINOR_AW'(m44i_pkg::MINORS - 1)) begin
            state_next    = m44i_pkg::ST_WAIT;
            wait_ret_next = m44i_pkg::ST_COF;
            wcnt_next     = '0;
            k_next        = '0;
            limb_next     = '0;
          end
        end
      end
      m44i_pkg::ST_COF: begin
        rd_addr_a  = {rs0, asel};
        minor_addr = m44i_pkg::MINOR_AW'(rpk) * m44i_pkg::MINOR_AW'(6)
                   + m44i_pkg::MINOR_AW'(m44i_pkg::pair_index(pa, pb));
        op.valid   = 1'b1;
        op.src     = m44i_pkg::SRC_MINOR;
        op.dst     = m44i_pkg::DST_COF;
        op.limb    = limb;
        op.neg     = (term == 2'd1) ^ row[0] ^ col[0];
        op.first   = (term == 2'd0) && (limb == 2'd0);
        op.last    = (term == 2'd2) && (limb == 2'd1);
        op.dest    = m44i_pkg::MINOR_AW'(k);
        if (limb == 2'd0) begin
          limb_next = 2'd1;
        end else begin
          limb_next = 2'd0;
          if (term == 2'd2) begin
            term_next = 2'd0;
            k_next    = k + m44i_pkg::IDX_W'(1);
            if (k == m44i_pkg::IDX_W'(m44i_pkg::ELEMS - 1)) begin
              state_next    = m44i_pkg::ST_WAIT;
              wait_ret_next = m44i_pkg::ST_DET;
              wcnt_next     = '0;
            end
          end else begin
            term_next = term + 2'd1;
          end
        end
      end
      m44i_pkg::ST_DET: begin
        rd_addr_a = {k[1:0], 2'd0};
        cof_addr  = {2'd0, k[1:0]};
        op.valid  = 1'b1;
        op.src    = m44i_pkg::SRC_COF;
        op.dst    = m44i_pkg::DST_DET;
        op.limb   = limb;
        op.neg    = 1'b0;
        op.first  = (k[1:0] == 2'd0) && (limb == 2'd0);
        op.last   = (k[1:0] == 2'd3) && (limb == 2'd2);
        op.dest   = '0;
        if (limb == 2'd2) begin
          limb_next = 2'd0;
          k_next    = k + m44i_pkg::IDX_W'(1);
          if (k[1:0] == 2'd3) begin
            k_next        = '0;
            state_next    = m44i_pkg::ST_WAIT;
            wait_ret_next = m44i_pkg::ST_DSETUP;
            wcnt_next     = '0;
          end
        end else begin
          limb_next = limb + 2'd1;
        end
      end
      m44i_pkg::ST_WAIT: begin
        wcnt_next = wcnt + 2'd1;
        if (wcnt == 2'(m44i_pkg::WAIT_CYCLES - 1)) begin
          state_next = wait_ret;
        end
      end
      m44i_pkg::ST_DSETUP: begin
        state_next = m44i_pkg::ST_DREAD;
      end
      m44i_pkg::ST_DREAD: begin
        state_next = det_zero ? m44i_pkg::ST_EMIT : m44i_pkg::ST_DGO;
      end
      m44i_pkg::ST_DGO: begin
        div_req.start = 1'b1;
        state_next    = m44i_pkg::ST_DRUN;
      end
      m44i_pkg::ST_DRUN: begin
        if (div_rsp.done) begin
          state_next = m44i_pkg::ST_EMIT;
        end
      end
      m44i_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          res_load = 1'b1;
          k_next   = k + m44i_pkg::IDX_W'(1);
          if (k == m44i_pkg::IDX_W'(m44i_pkg::ELEMS - 1)) begin
            state_next = m44i_pkg::ST_LOAD;
          end else begin
            state_next = m44i_pkg::ST_DREAD;
          end
        end
      end
      default: begin
        state_next = m44i_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem[q_data.index] <= q_data.value;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (s2_op.valid && s2_op.last && (s2_op.dst == m44i_pkg::DST_MINOR)) begin
      minor_bank[s2_op.dest] <= acc_next[m44i_pkg::MIN_W-1:0];
    end
    minor_rd <= minor_bank[minor_addr];
  end

  always_ff @(posedge clk) begin
    if (s2_op.valid && s2_op.last && (s2_op.dst == m44i_pkg::DST_COF)) begin
      cof_bank[s2_op.dest[m44i_pkg::IDX_W-1:0]] <= acc_next[m44i_pkg::COF_W-1:0];
    end
    cof_rd <= cof_bank[cof_addr];
  end

  assign a_opd = {rd_a[m44i_pkg::DATA_W-1], rd_a};

  always_comb begin
    case (s1_op.src)
      m44i_pkg::SRC_ELEM: begin
        b_opd = {rd_b[m44i_pkg::DATA_W-1], rd_b};
      end
      m44i_pkg::SRC_MINOR: begin
        b_opd = (s1_op.limb == 2'd0) ? {1'b0, minor_rd[31:0]} : minor_rd[64:32];
      end
      m44i_pkg::SRC_COF: begin
        case (s1_op.limb)
          2'd0:    b_opd = {1'b0, cof_rd[31:0]};
          2'd1:    b_opd = {1'b0, cof_rd[63:32]};
          default: b_opd = cof_rd[96:64];
        endcase
      end
      default: begin
        b_opd = '0;
      end
    endcase
  end

  assign term_ext = m44i_pkg::ACC_W'(prod);

  always_comb begin
    case (s2_op.limb)
      2'd0:    term_sh = term_ext;
      2'd1:    term_sh = term_ext <<< 32;
      default: term_sh = term_ext <<< 64;
    endcase
  end

  assign acc_base = s2_op.first ? '0 : acc;
  assign acc_next = s2_op.neg ? (acc_base - term_sh) : (acc_base + term_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_op <= '0;
      s2_op <= '0;
    end else begin
      s1_op <= op;
      s2_op <= s1_op;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_opd * b_opd;
    if (s2_op.valid) begin
      acc <= acc_next;
      if (s2_op.last && (s2_op.dst == m44i_pkg::DST_DET)) begin
        det <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == m44i_pkg::ST_DSETUP) begin
      det_neg  <= det[m44i_pkg::ACC_W-1];
      det_mag  <= det[m44i_pkg::ACC_W-1] ? (~det + m44i_pkg::ACC_W'(1)) : det;
      det_zero <= (det == '0);
    end
    if ((state == m44i_pkg::ST_DRUN) && div_rsp.done) begin
      q_res <= div_rsp.quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result_value <= det_zero ? '0 : q_res;
      result_index <= k;
      singular     <= det_zero;
      last_result  <= (k == m44i_pkg::IDX_W'(m44i_pkg::ELEMS - 1));
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/matrix4x4_inverse_top.sv
// ----------------------------------------------------------------------------
// matrix4x4_inverse_top
// Fixed-point 4x4 matrix inverse by cofactors and Cramer's rule.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, element_value) takes the sixteen
// elements of a matrix in row-major order. The output channel (out_valid,
// out_ready) returns sixteen inverse elements in row-major order, each with
// its index, the singular flag and a last marker on the sixteenth.
// Elements are tagged by the front and pass through a four-entry queue, so
// the source may run ahead while the engine is busy with the prior matrix.
// The engine loads one element per cycle while the queue has one, then runs
// 144 multiply-accumulate steps on a single shared 33x33 multiplier, with
// pauses for the pipeline to drain, and then a bit-serial divider for each
// inverse element. A singular matrix skips the divider.
// Reset clears the element counter, the queue, the sequencer and the output
// valid flag. A stalled receiver holds the current result in the output
// register and pauses the engine; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4x4_inverse_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] element_value,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic [31:0]      result_value,
  output logic [3:0]       result_index,
  output logic             singular,
  output logic             last_result,
  output logic             out_valid,
  input  wire logic        out_ready
);

  m44i_pkg::elem_t    push_data;
  logic               push_valid;
  logic               push_ready;
  m44i_pkg::elem_t    pop_data;
  logic               pop_valid;
  logic               pop;
  m44i_pkg::div_req_t div_req;
  m44i_pkg::div_rsp_t div_rsp;

  m44i_front u_front (
    .clk           (clk),
    .rst           (rst),
    .element_value (element_value),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .push_data     (push_data),
    .push_valid    (push_valid),
    .push_ready    (push_ready)
  );

  m44i_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop        (pop)
  );

  m44i_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  m44i_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_data       (pop_data),
    .q_valid      (pop_valid),
    .q_pop        (pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .result_value (result_value),
    .result_index (result_index),
    .singular     (singular),
    .last_result  (last_result),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule

`default_nettype wire

>>> verif/matrix4x4_inverse_top_tb.sv
// ----------------------------------------------------------------------------
// matrix4x4_inverse_top_tb
// Self-checking testbench for the fixed-point 4x4 matrix inverse.
// ----------------------------------------------------------------------------
// Matrices are streamed in element by element. They are directed cases first
// (identity, zero, saturating and extreme values), then random matrices of
// several kinds. A scoreboard computes the exact adjugate and determinant
// for each completed matrix. It rounds and saturates every inverse element
// and compares the sixteen results of each matrix field by field, in order.
// Both sides idle at random in two phases; in a third, neither idles.
// ----------------------------------------------------------------------------
`default_nettype none

class inverse_scoreboard;
  typedef logic signed [255:0] wide_t;
  typedef struct {
    logic [31:0] value;
    logic [3:0]  index;
    logic        sing;
    logic        last;
  } inv_result_t;

  int          frac;
  logic [31:0] elems [16];
  int          fill_count;
  inv_result_t pending [$];
  int          errors;
  int          matrices;
  int          singular_seen;

  function new(int frac_bits);
    frac = frac_bits;
    fill_count = 0;
    errors = 0;
    matrices = 0;
    singular_seen = 0;
  endfunction

  function wide_t elem_at(int r, int c);
    wide_t w;
    w = $signed(elems[r * 4 + c]);
    return w;
  endfunction

  function wide_t cofactor_of(int row, int col);
    wide_t m [3][3];
    wide_t d;
    int    ri;
    int    ci;
    ri = 0;
    for (int r = 0; r < 4; r++) begin
      if (r != row) begin
        ci = 0;
        for (int c = 0; c < 4; c++) begin
          if (c != col) begin
            m[ri][ci] = elem_at(r, c);
            ci++;
          end
        end
        ri++;
      end
    end
    d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
      - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
      + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    return ((row + col) % 2) ? -d : d;
  endfunction

  function logic [31:0] scaled_quotient(wide_t cof, wide_t det);
    logic        neg;
    logic [255:0] ca;
    logic [255:0] da;
    logic [255:0] q;
    logic [255:0] limit;
    neg   = cof[255] != det[255];
    ca    = cof[255] ? -cof : cof;
    da    = det[255] ? -det : det;
    q     = ((ca << (2 * frac + 1)) + da) / (da << 1);
    limit = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
    if (q > limit) begin
      q = limit;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function void note_element(logic [31:0] value);
    wide_t       adj [16];
    wide_t       det;
    inv_result_t r;
    elems[fill_count] = value;
    fill_count = (fill_count + 1) % 16;
    if (fill_count != 0) begin
      return;
    end
    for (int k = 0; k < 16; k++) begin
      adj[k] = cofactor_of(k % 4, k / 4);
    end
    det = 0;
    for (int k = 0; k < 4; k++) begin
      det = det + elem_at(k, 0) * adj[k];
    end
    matrices++;
    if (det == 0) begin
      singular_seen++;
    end
    for (int k = 0; k < 16; k++) begin
      r.value = (det == 0) ? 32'd0 : scaled_quotient(adj[k], det);
      r.index = k[3:0];
      r.sing  = (det == 0);
      r.last  = (k == 15);
      pending.push_back(r);
    end
  endfunction

  function void check_result(logic [31:0] value, logic [3:0] index, logic sing,
                             logic last);
    inv_result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result transfer: result_value %h index %0d", value, index);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (value !== e.value) begin
      $error("result_value: expected %h, actual %h", e.value, value);
      errors++;
    end
    if (index !== e.index) begin
      $error("result_index: expected %0d, actual %0d", e.index, index);
      errors++;
    end
    if (sing !== e.sing) begin
      $error("singular: expected %0b, actual %0b", e.sing, sing);
      errors++;
    end
    if (last !== e.last) begin
      $error("last_result: expected %0b, actual %0b", e.last, last);
      errors++;
    end
  endfunction
endclass

module matrix4x4_inverse_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = 16;
  localparam int STALL_LIMIT = 20000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic                        clk;
  logic                        rst;
  logic [m44i_pkg::DATA_W-1:0] element_value;
  logic                        in_valid;
  logic                        in_ready;
  logic [m44i_pkg::DATA_W-1:0] result_value;
  logic [m44i_pkg::IDX_W-1:0]  result_index;
  logic                        singular;
  logic                        last_result;
  logic                        out_valid;
  logic                        out_ready;

  int                tx_idle;
  int                rx_idle;
  int                quiet_cycles;
  logic [31:0]       mat [16];
  inverse_scoreboard scoreboard;

  matrix4x4_inverse_top #(.FRAC_BITS(FRAC)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .element_value(element_value),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .result_value (result_value),
    .result_index (result_index),
    .singular     (singular),
    .last_result  (last_result),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      scoreboard.note_element(element_value);
    end
    if (!rst && out_valid && out_ready) begin
      scoreboard.check_result(result_value, result_index, singular, last_result);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (!in_valid && scoreboard.pending.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_element(logic [31:0] value);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_matrix();
    for (int k = 0; k < 16; k++) begin
      send_element(mat[k]);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (scoreboard.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);
  endtask

  task automatic make_diagonal(logic [31:0] d);
    for (int k = 0; k < 16; k++) begin
      mat[k] = (k % 5 == 0) ? d : 32'd0;
    end
  endtask

  task automatic make_random();
    int kind;
    int src;
    int dst;
    kind = $urandom_range(4);
    for (int k = 0; k < 16; k++) begin
      case (kind)
        0: mat[k] = $urandom();
        1: mat[k] = $urandom_range(8 * ONE) - 4 * ONE;
        2: mat[k] = $urandom_range(ONE) - ONE / 2 + ((k % 5 == 0) ? 4 * ONE : 0);
        default: mat[k] = $urandom_range(2 * ONE) - ONE;
      endcase
    end
    if (kind == 4) begin
      src = $urandom_range(3);
      dst = (src + 1 + $urandom_range(2)) % 4;
      for (int c = 0; c < 4; c++) begin
        mat[dst * 4 + c] = mat[src * 4 + c];
      end
    end
  endtask

  initial begin
    scoreboard    = new(FRAC);
    rst           = 1'b1;
    in_valid      = 1'b0;
    element_value = '0;
    tx_idle       = 16;
    rx_idle       = 68;
    quiet_cycles  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    make_diagonal(ONE);
    send_matrix();
    make_diagonal(32'd0);
    send_matrix();
    make_diagonal(32'd1);
    send_matrix();
    make_diagonal(32'hFFFF_FFFF);
    send_matrix();
    for (int k = 0; k < 16; k++) begin
      mat[k] = (k % 5 == 0) ? ((k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000)
                            : ((k % 3 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end
    send_matrix();
    wait_drained();

    for (int n = 0; n < 24; n++) begin
      if (n == 8) begin
        tx_idle = 68;
        rx_idle = 16;
      end else if (n == 16) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      make_random();
      send_matrix();
    end
    wait_drained();

    $display("Covered %0d matrices, %0d singular, with directed extremes and three idle phases.",
             scoreboard.matrices, scoreboard.singular_seen);
    if (scoreboard.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

>>> matrix4x4_inverse_top.f
rtl/core/m44i_pkg.sv
rtl/core/m44i_front.sv
rtl/core/m44i_queue.sv
rtl/core/m44i_divider.sv
rtl/core/m44i_engine.sv
rtl/core/matrix4x4_inverse_top.sv
verif/matrix4x4_inverse_top_tb.sv
